// ===== sv/one_of_four_frame_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// one_of_four_frame_decoder_top_macros
// Assertion macros for the one-of-four frame decoder, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ONE_OF_FOUR_FRAME_DECODER_TOP_MACROS_SVH
`define ONE_OF_FOUR_FRAME_DECODER_TOP_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge outside reset
`define OFD_CHECK(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("ofd check failed");

// antecedent implies consequent on the same edge
`define OFD_CHECK_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ofd implication failed");

`else

`define OFD_CHECK(label, cond)
`define OFD_CHECK_IMPL(label, ante, cons)

`endif

`endif

// ===== sv/ofd_pkg.sv =====
// ----------------------------------------------------------------------------
// ofd_pkg
// Shared types and constants of the one-of-four frame decoder.
// ----------------------------------------------------------------------------
package ofd_pkg;

   // decoded byte capacity of the receive buffer
   localparam int MAX_DECODED_BYTES = 256;
   localparam int CNT_W             = $clog2(MAX_DECODED_BYTES + 1);
   localparam int LIMIT_W           = 9;
   localparam int CMP_W             = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int BITS_W            = 12;

   // frame status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FORMAT   = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // line patterns and one-hot symbols
   localparam logic [4:0] START_PATTERN = 5'h17;
   localparam logic [4:0] END_PATTERN   = 5'h1D;
   localparam logic [7:0] SYM_VAL0      = 8'h02;
   localparam logic [7:0] SYM_VAL1      = 8'h08;
   localparam logic [7:0] SYM_VAL2      = 8'h20;
   localparam logic [7:0] SYM_VAL3      = 8'h80;

   // raw bits needed for a minimal frame
   localparam logic [3:0] RAW_MIN = 4'd10;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic [3:0] valid_bits;
      logic       last_byte;
   } ofd_req_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic              byte_valid;
      logic              frame_done;
      logic [1:0]        status;
      logic [BITS_W-1:0] data_bits;
   } ofd_rsp_type;

endpackage

// ===== sv/ofd_core.sv =====
// ----------------------------------------------------------------------------
// ofd_core
// Frame state and single-pass decode of one raw byte per step.
// ----------------------------------------------------------------------------
module ofd_core import ofd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  ofd_req_type       item,
   input  logic [CMP_W-1:0]  byte_limit,
   output logic              has_result,
   output ofd_rsp_type       result
);

   // frame phase codes
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_DATA  = 2'd1;
   localparam logic [1:0] PH_END   = 2'd2;
   localparam logic [1:0] PH_ERROR = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        shift_ff, shift_in;
   logic [3:0]        count_ff, count_in;
   logic [3:0]        raw_ff, raw_in;
   logic [7:0]        acc_ff, acc_in;
   logic [1:0]        pairs_ff, pairs_in;
   logic [CNT_W-1:0]  bytes_ff, bytes_in;
   logic [BITS_W-1:0] total_ff, total_in;
   logic [1:0]        err_ff, err_in;

   // walk the valid bits, then fold in at most one symbol
   always_comb begin
      logic [3:0]        nb;
      logic [7:0]        sh;
      logic [3:0]        cnt;
      logic [1:0]        ph;
      logic [1:0]        err;
      logic [1:0]        err_f;
      logic              sym_hit;
      logic [1:0]        sym_val;
      logic [7:0]        sym;
      logic              bitv;
      logic [4:0]        raw_sum;
      logic [3:0]        raw_new;
      logic [7:0]        acc_new;
      logic [1:0]        pairs_new;
      logic              have_byte;
      logic [7:0]        byte_out;
      logic [CNT_W-1:0]  bytes_new;
      logic [BITS_W-1:0] total_new;
      logic [CMP_W-1:0]  lim;
      logic              at_limit;

      nb        = (item.valid_bits > 4'd8) ? 4'd8 : item.valid_bits;
      sh        = shift_ff;
      cnt       = count_ff;
      ph        = phase_ff;
      err       = err_ff;
      sym_hit   = 1'b0;
      sym_val   = 2'd0;
      sym       = 8'd0;
      bitv      = 1'b0;
      have_byte = 1'b0;
      byte_out  = 8'd0;

      lim      = (byte_limit > CMP_W'(MAX_DECODED_BYTES)) ? CMP_W'(MAX_DECODED_BYTES)
                                                          : byte_limit;
      at_limit = (CMP_W'(bytes_ff) >= lim);

      // bit-by-bit pattern and symbol gathering
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < nb) begin
            bitv = item.raw_byte[7-i];
            case (ph)
               PH_START: begin
                  sh  = {sh[6:0], bitv};
                  cnt = cnt + 4'd1;
                  if (cnt == 4'd5) begin
                     if (sh[4:0] != START_PATTERN) begin
                        ph  = PH_ERROR;
                        err = STATUS_FORMAT;
                     end else begin
                        ph = PH_DATA;
                     end
                     sh  = 8'd0;
                     cnt = 4'd0;
                  end
               end
               PH_DATA: begin
                  sh  = {sh[6:0], bitv};
                  cnt = cnt + 4'd1;
                  if (cnt == 4'd8) begin
                     sym = sh;
                     sh  = 8'd0;
                     cnt = 4'd0;
                     if (sym[7:3] == END_PATTERN) begin
                        ph = PH_END;
                     end else begin
                        case (sym)
                           SYM_VAL0: begin
                              sym_hit = 1'b1;
                              sym_val = 2'd0;
                           end
                           SYM_VAL1: begin
                              sym_hit = 1'b1;
                              sym_val = 2'd1;
                           end
                           SYM_VAL2: begin
                              sym_hit = 1'b1;
                              sym_val = 2'd2;
                           end
                           SYM_VAL3: begin
                              sym_hit = 1'b1;
                              sym_val = 2'd3;
                           end
                           default: begin
                              ph  = PH_ERROR;
                              err = STATUS_FORMAT;
                           end
                        endcase
                        // byte completes with the buffer already full
                        if (sym_hit && (pairs_ff == 2'd3) && at_limit) begin
                           ph  = PH_ERROR;
                           err = STATUS_OVERFLOW;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // raw bit total, saturating
      raw_sum = {1'b0, raw_ff} + {1'b0, nb};
      raw_new = (raw_sum >= {1'b0, RAW_MIN}) ? RAW_MIN : raw_sum[3:0];

      // pack the symbol value into the byte
      acc_new   = acc_ff;
      pairs_new = pairs_ff;
      bytes_new = bytes_ff;
      total_new = total_ff;
      if (sym_hit) begin
         acc_new   = acc_ff | ({6'd0, sym_val} << {pairs_ff, 1'b0});
         pairs_new = pairs_ff + 2'd1;
         total_new = total_ff + BITS_W'(2);
         if ((pairs_ff == 2'd3) && !at_limit) begin
            have_byte = 1'b1;
            byte_out  = acc_new;
            bytes_new = bytes_ff + CNT_W'(1);
            acc_new   = 8'd0;
            pairs_new = 2'd0;
         end
      end

      // frame close: short frame and residual byte
      err_f = err;
      if (item.last_byte) begin
         if ((err_f == STATUS_OK) && (raw_new < RAW_MIN)) begin
            err_f = STATUS_FORMAT;
         end
         if ((err_f == STATUS_OK) && (pairs_new != 2'd0)) begin
            if (at_limit) begin
               err_f = STATUS_OVERFLOW;
            end else begin
               have_byte = 1'b1;
               byte_out  = acc_new;
            end
         end
      end

      // result item
      has_result = 1'b0;
      result     = '0;
      if (item.last_byte) begin
         has_result        = 1'b1;
         result.frame_done = 1'b1;
         if (err_f != STATUS_OK) begin
            result.status = err_f;
         end else begin
            result.data_byte  = byte_out;
            result.byte_valid = have_byte;
            result.data_bits  = total_new;
         end
      end else if (have_byte) begin
         has_result        = 1'b1;
         result.data_byte  = byte_out;
         result.byte_valid = 1'b1;
      end

      // next frame state
      if (item.last_byte) begin
         phase_in = PH_START;
         shift_in = 8'd0;
         count_in = 4'd0;
         raw_in   = 4'd0;
         acc_in   = 8'd0;
         pairs_in = 2'd0;
         bytes_in = '0;
         total_in = '0;
         err_in   = STATUS_OK;
      end else begin
         phase_in = ph;
         shift_in = sh;
         count_in = cnt;
         raw_in   = raw_new;
         acc_in   = acc_new;
         pairs_in = pairs_new;
         bytes_in = bytes_new;
         total_in = total_new;
         err_in   = err;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         shift_ff <= 8'd0;
         count_ff <= 4'd0;
         raw_ff   <= 4'd0;
         acc_ff   <= 8'd0;
         pairs_ff <= 2'd0;
         bytes_ff <= '0;
         total_ff <= '0;
         err_ff   <= STATUS_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         raw_ff   <= raw_in;
         acc_ff   <= acc_in;
         pairs_ff <= pairs_in;
         bytes_ff <= bytes_in;
         total_ff <= total_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== sv/one_of_four_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// one_of_four_frame_decoder_top
// 1-out-of-4 receive decoder: request register, decode core, result register.
// ----------------------------------------------------------------------------
// Flow: a request passes the request register, the combinational decode core
// and the result register; a stalled full result register holds the request.
// Throughput: one request per cycle when not stalled, set by one decode per byte.
// Reset: synchronous, active high; clears frame state, byte limit to 256.
// ----------------------------------------------------------------------------
`include "one_of_four_frame_decoder_top_macros.svh"

module one_of_four_frame_decoder_top import ofd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_raw_byte,
   input  logic [3:0]          req_valid_bits,
   input  logic                req_last_byte,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_frame_done,
   output logic [1:0]          rsp_status,
   output logic [BITS_W-1:0]   rsp_data_bits,
   // register write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIMIT_W-1:0]  csr_byte_limit
);

   logic              in_vld_ff, in_vld_in;
   ofd_req_type       in_item_ff;
   logic              out_vld_ff, out_vld_in;
   ofd_rsp_type       out_ff;
   logic [CMP_W-1:0]  limit_ff;
   logic              out_free;
   logic              step;
   logic              accept;
   logic              has_result;
   ofd_rsp_type       result;

   // handshake control
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !step);
   assign csr_ready = 1'b1;

   always_comb begin
      if (step && has_result) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.raw_byte   <= req_raw_byte;
         in_item_ff.valid_bits <= req_valid_bits;
         in_item_ff.last_byte  <= req_last_byte;
      end
   end

   // byte limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CMP_W'(MAX_DECODED_BYTES);
      end else if (csr_valid && csr_ready) begin
         limit_ff <= CMP_W'(csr_byte_limit);
      end
   end

   // decode core
   ofd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .byte_limit (limit_ff),
      .has_result (has_result),
      .result     (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_data_byte  = out_ff.data_byte;
   assign rsp_byte_valid = out_ff.byte_valid;
   assign rsp_frame_done = out_ff.frame_done;
   assign rsp_status     = out_ff.status;
   assign rsp_data_bits  = out_ff.data_bits;

   // checks
   `OFD_CHECK_IMPL(a_err_clean, rsp_valid && (rsp_status != STATUS_OK),
      !rsp_byte_valid && (rsp_data_bits == '0) && (rsp_data_byte == 8'd0))
   `OFD_CHECK_IMPL(a_mid_frame_byte, rsp_valid && !rsp_frame_done,
      rsp_byte_valid && (rsp_status == STATUS_OK) && (rsp_data_bits == '0))
   `OFD_CHECK_IMPL(a_status_code, rsp_valid,
      (rsp_status == STATUS_OK) || (rsp_status == STATUS_FORMAT) ||
      (rsp_status == STATUS_OVERFLOW))

endmodule
